// ----- rtl/core/uvs_pkg.sv -----
`timescale 1ns / 1ps
package uvs_pkg;

   localparam int MAX_SLICES = 1024;
   localparam int MAX_STACKS = 1024;
   localparam int MIN_SLICES = 3;
   localparam int MIN_STACKS = 2;
   localparam int TRIG_DEPTH = 1024;
   localparam int TRIG_AW = $clog2(TRIG_DEPTH);

   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int RADIUS_W = 16;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int PHASE_W = 16;
   localparam int COORD_W = 17;
   localparam int TRIG_W = 18;
   localparam int CORNER_W = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STACKS = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
   localparam logic [COUNT_W-1:0] SLICES_RESET = 11'd16;
   localparam logic [COUNT_W-1:0] STACKS_RESET = 11'd8;

   localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;
   localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [COORD_W-1:0] sine_tab_type [TRIG_DEPTH];

   // phases of one quad: upper/lower latitude, this/next longitude
   typedef struct packed {
      logic [PHASE_W-1:0] lat_u;
      logic [PHASE_W-1:0] lat_l;
      logic [PHASE_W-1:0] lon_a;
      logic [PHASE_W-1:0] lon_b;
      logic               bad;
   } quad_phase_type;

   // odd taylor series in q30, rounded to q16
   function automatic logic [COORD_W-1:0] series_sine(input int unsigned i);
      logic [63:0] x;
      logic [63:0] t;
      logic [63:0] r;
      longint      sum;
      x = (HALF_PI_Q30 * 64'(i)) / 64'(TRIG_DEPTH);
      t = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = sum - longint'(t);
         end else begin
            sum = sum + longint'(t);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (64'(sum) + 64'd8192) >> 14;
      return r[COORD_W-1:0];
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      for (int i = 0; i < TRIG_DEPTH; i++) begin
         tab[i] = series_sine(i);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

// ----- rtl/core/uv_sphere_vertex_generator.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake              word
// req       in   req_valid/req_stall    stack_index, slice_index
// rsp       out  rsp_valid/rsp_stall    vx, vy, vz, corner, last, bad_index
// csr       in   csr_write_enable       csr_index, csr_wdata
//
// six result words per quad, one per cycle while rsp_stall is low, sent by the
// vertex emitter on the result channel; lookups for the next quad overlap the emission
// the first word passes the 18 divider stages, the quad queue, 4 lookup issues, the
// rom read, the hand-over to the emitter and the output register
// reset is synchronous; registers return to radius 256, 16 slices, 8 stacks
// rsp_stall holds the output word; req_stall rises once the quad queue is full
module uv_sphere_vertex_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [uvs_pkg::INDEX_W-1:0]         req_stack_index,
   input  logic [uvs_pkg::INDEX_W-1:0]         req_slice_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [uvs_pkg::COORD_W-1:0]  rsp_vx,
   output logic signed [uvs_pkg::COORD_W-1:0]  rsp_vy,
   output logic signed [uvs_pkg::COORD_W-1:0]  rsp_vz,
   output logic [uvs_pkg::CORNER_W-1:0]        rsp_corner,
   output logic                                rsp_last,
   output logic                                rsp_bad_index,
   input  logic                                csr_write_enable,
   input  logic [uvs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [uvs_pkg::CSR_W-1:0]           csr_wdata
);
   import uvs_pkg::*;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                      input int lo, input int hi);
      if (v < COUNT_W'(lo)) begin
         return COUNT_W'(lo);
      end
      if (v > COUNT_W'(hi)) begin
         return COUNT_W'(hi);
      end
      return v;
   endfunction

   logic [RADIUS_W-1:0] radius_ff;
   logic [COUNT_W-1:0]  slice_count_ff;
   logic [COUNT_W-1:0]  stack_count_ff;

   logic                q_push;
   quad_phase_type      q_push_data;
   logic                q_pop;
   quad_phase_type      q_head;
   logic                q_full;
   logic                q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= RADIUS_RESET;
         slice_count_ff <= SLICES_RESET;
         stack_count_ff <= STACKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_SLICES: slice_count_ff <= clamp_count(csr_wdata[COUNT_W-1:0],
                                                      MIN_SLICES, MAX_SLICES);
            CSR_STACKS: stack_count_ff <= clamp_count(csr_wdata[COUNT_W-1:0],
                                                      MIN_STACKS, MAX_STACKS);
            default: ;
         endcase
      end
   end

   uvs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .stack_index (req_stack_index),
      .slice_index (req_slice_index),
      .slice_count (slice_count_ff),
      .stack_count (stack_count_ff),
      .q_full      (q_full),
      .push        (q_push),
      .push_data   (q_push_data)
   );

   uvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   uvs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .radius        (radius_ff),
      .q_empty       (q_empty),
      .q_data        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_vx        (rsp_vx),
      .rsp_vy        (rsp_vy),
      .rsp_vz        (rsp_vz),
      .rsp_corner    (rsp_corner),
      .rsp_last      (rsp_last),
      .rsp_bad_index (rsp_bad_index)
   );

endmodule

// ----- rtl/core/uvs_sine_rom.sv -----
`timescale 1ns / 1ps
module uvs_sine_rom (
   input  logic                        clock,
   input  logic [uvs_pkg::TRIG_AW-1:0] addr_a,
   input  logic [uvs_pkg::TRIG_AW-1:0] addr_b,
   output logic [uvs_pkg::COORD_W-1:0] data_a,
   output logic [uvs_pkg::COORD_W-1:0] data_b
);
   import uvs_pkg::*;

   logic [COORD_W-1:0] data_a_ff;
   logic [COORD_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      data_a_ff <= SINE_TAB[addr_a];
      data_b_ff <= SINE_TAB[addr_b];
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

// ----- rtl/core/uvs_queue.sv -----
`timescale 1ns / 1ps
module uvs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  uvs_pkg::quad_phase_type push_data,
   input  logic                    pop,
   output uvs_pkg::quad_phase_type head,
   output logic                    full,
   output logic                    empty
);
   import uvs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   quad_phase_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [PTR_W:0]     count_ff;
   logic [PTR_W:0]     count_in;

   assign full  = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

// ----- rtl/core/uvs_front.sv -----
`timescale 1ns / 1ps
module uvs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [uvs_pkg::INDEX_W-1:0] stack_index,
   input  logic [uvs_pkg::INDEX_W-1:0] slice_index,
   input  logic [uvs_pkg::COUNT_W-1:0] slice_count,
   input  logic [uvs_pkg::COUNT_W-1:0] stack_count,
   input  logic                        q_full,
   output logic                        push,
   output uvs_pkg::quad_phase_type     push_data
);
   import uvs_pkg::*;

   localparam int LANES = 4;
   localparam int QUOT_W = PHASE_W + 1;
   localparam int DVD_W = INDEX_W + 1 + PHASE_W;
   localparam int REM_W = DVD_W - QUOT_W;

   logic                     adv;
   logic                     accept;
   logic                     bad;
   logic [INDEX_W:0]         k_next;
   logic [INDEX_W:0]         j_next;
   logic [DVD_W-1:0]         dvd [LANES];
   logic [COUNT_W-1:0]       dvs [LANES];

   logic [QUOT_W:0]          v_ff;
   logic [QUOT_W:0]          bad_ff;
   logic [REM_W-1:0]         rem_ff [QUOT_W+1][LANES];
   logic [QUOT_W-1:0]        low_ff [QUOT_W+1][LANES];
   logic [REM_W-1:0]         rem_in [QUOT_W][LANES];
   logic [QUOT_W-1:0]        low_in [QUOT_W][LANES];

   // the whole divider advances only while the queue has room
   assign adv       = !q_full;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_comb begin
      k_next = {1'b0, stack_index} + 1'b1;
      j_next = {1'b0, slice_index} + 1'b1;
      bad = (COUNT_W'(stack_index) >= stack_count) || (COUNT_W'(slice_index) >= slice_count);
      dvd[0] = DVD_W'({stack_index, {(PHASE_W-1){1'b0}}}) + DVD_W'(stack_count >> 1);
      dvd[1] = DVD_W'({k_next, {(PHASE_W-1){1'b0}}}) + DVD_W'(stack_count >> 1);
      dvd[2] = DVD_W'({slice_index, {PHASE_W{1'b0}}}) + DVD_W'(slice_count >> 1);
      dvd[3] = DVD_W'({j_next, {PHASE_W{1'b0}}}) + DVD_W'(slice_count >> 1);
      dvs[0] = stack_count;
      dvs[1] = stack_count;
      dvs[2] = slice_count;
      dvs[3] = slice_count;
   end

   // one restoring step per stage, four lanes side by side
   always_comb begin
      logic [REM_W:0] r;
      for (int s = 0; s < QUOT_W; s++) begin
         for (int l = 0; l < LANES; l++) begin
            r = {rem_ff[s][l], low_ff[s][l][QUOT_W-1]};
            if (r >= dvs[l]) begin
               rem_in[s][l] = REM_W'(r - dvs[l]);
               low_in[s][l] = {low_ff[s][l][QUOT_W-2:0], 1'b1};
            end else begin
               rem_in[s][l] = REM_W'(r);
               low_in[s][l] = {low_ff[s][l][QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[QUOT_W-1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad_ff <= {bad_ff[QUOT_W-1:0], bad};
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= dvd[l][DVD_W-1:QUOT_W];
            low_ff[0][l] <= dvd[l][QUOT_W-1:0];
            for (int s = 0; s < QUOT_W; s++) begin
               rem_ff[s+1][l] <= rem_in[s][l];
               low_ff[s+1][l] <= low_in[s][l];
            end
         end
      end
   end

   assign push = v_ff[QUOT_W] && adv;

   always_comb begin
      push_data.lat_u = QUARTER_TURN - low_ff[QUOT_W][0][PHASE_W-1:0];
      push_data.lat_l = QUARTER_TURN - low_ff[QUOT_W][1][PHASE_W-1:0];
      push_data.lon_a = low_ff[QUOT_W][2][PHASE_W-1:0];
      push_data.lon_b = low_ff[QUOT_W][3][PHASE_W-1:0];
      push_data.bad   = bad_ff[QUOT_W];
   end

endmodule

// ----- rtl/core/uvs_back.sv -----
`timescale 1ns / 1ps
module uvs_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [uvs_pkg::RADIUS_W-1:0]        radius,
   input  logic                                q_empty,
   input  uvs_pkg::quad_phase_type             q_data,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [uvs_pkg::COORD_W-1:0]  rsp_vx,
   output logic signed [uvs_pkg::COORD_W-1:0]  rsp_vy,
   output logic signed [uvs_pkg::COORD_W-1:0]  rsp_vz,
   output logic [uvs_pkg::CORNER_W-1:0]        rsp_corner,
   output logic                                rsp_last,
   output logic                                rsp_bad_index
);
   import uvs_pkg::*;

   localparam int PROD_W = 36;
   localparam logic [1:0] FETCH_LAT_U = 2'd0;
   localparam logic [1:0] FETCH_LAT_L = 2'd1;
   localparam logic [1:0] FETCH_LON_A = 2'd2;
   localparam logic [1:0] FETCH_LON_B = 2'd3;
   // bit c: corner c sits on the lower ring / at the next longitude
   localparam logic [5:0] LOWER_RING = 6'b110010;
   localparam logic [5:0] NEXT_LON = 6'b101100;

   typedef struct packed {
      logic               neg;
      logic               full;
      logic [TRIG_AW-1:0] addr;
   } trig_ref_type;

   function automatic trig_ref_type quarter_map(input logic [PHASE_W-1:0] p);
      logic [PHASE_W-2:0] m;
      trig_ref_type       t;
      if (p[PHASE_W-2]) begin
         m = (PHASE_W-1)'(QUARTER_TURN) - {1'b0, p[PHASE_W-3:0]};
      end else begin
         m = {1'b0, p[PHASE_W-3:0]};
      end
      t.neg  = p[PHASE_W-1];
      t.full = m[PHASE_W-2];
      t.addr = m[PHASE_W-3 -: TRIG_AW];
      return t;
   endfunction

   function automatic logic signed [TRIG_W-1:0] trig_value(input logic neg, input logic full,
                                                           input logic [COORD_W-1:0] mag);
      logic signed [TRIG_W-1:0] v;
      v = full ? TRIG_W'(65536) : signed'({1'b0, mag});
      return neg ? -v : v;
   endfunction

   // round to nearest, half away from zero, drop 16 fraction bits
   function automatic logic signed [COORD_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0]        mag;
      logic [PROD_W-1:0]        r;
      logic signed [COORD_W-1:0] v;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      r = mag + PROD_W'(32768);
      v = signed'(r[COORD_W+15:16]);
      return p[PROD_W-1] ? -v : v;
   endfunction

   // fetch side
   logic                      busy_ff;
   logic                      busy_in;
   logic [1:0]                ph_ff;
   logic [1:0]                ph_in;
   logic                      start;
   logic                      issue_v;
   logic [1:0]                issue_ph;
   logic [PHASE_W-1:0]        issue_phase;
   trig_ref_type              sin_ref;
   trig_ref_type              cos_ref;
   logic                      arr_v_ff;
   logic [1:0]                arr_ph_ff;
   trig_ref_type              arr_sin_ff;
   trig_ref_type              arr_cos_ff;
   logic [COORD_W-1:0]        rom_sin;
   logic [COORD_W-1:0]        rom_cos;
   logic signed [TRIG_W-1:0]  sval;
   logic signed [TRIG_W-1:0]  cval;
   logic signed [COORD_W-1:0] rad_s;
   logic signed [COORD_W-1:0] ring_rnd;
   logic signed [COORD_W-1:0] vy_rnd;

   // work set, filled by the fetch side
   logic                      work_full_ff;
   logic                      work_full_in;
   logic                      work_bad_ff;
   logic signed [COORD_W-1:0] w_ring_u_ff, w_ring_l_ff, w_vy_u_ff, w_vy_l_ff;
   logic signed [TRIG_W-1:0]  w_sin_a_ff, w_cos_a_ff, w_sin_b_ff, w_cos_b_ff;

   // emit set
   logic                      emit_full_ff;
   logic                      emit_full_in;
   logic [CORNER_W-1:0]       corner_ff;
   logic [CORNER_W-1:0]       corner_in;
   logic                      e_bad_ff;
   logic signed [COORD_W-1:0] e_ring_u_ff, e_ring_l_ff, e_vy_u_ff, e_vy_l_ff;
   logic signed [TRIG_W-1:0]  e_sin_a_ff, e_cos_a_ff, e_sin_b_ff, e_cos_b_ff;
   logic                      emit_go;
   logic                      emit_done;
   logic                      xfer;
   logic                      lower;
   logic                      nxt;
   logic signed [COORD_W-1:0] ring_sel;
   logic signed [COORD_W-1:0] vy_sel;
   logic signed [TRIG_W-1:0]  sin_sel;
   logic signed [TRIG_W-1:0]  cos_sel;
   logic signed [COORD_W-1:0] vx_rnd;
   logic signed [COORD_W-1:0] vz_rnd;

   // output word
   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_vx_ff, rsp_vy_ff, rsp_vz_ff;
   logic [CORNER_W-1:0]       rsp_corner_ff;
   logic                      rsp_last_ff;
   logic                      rsp_bad_ff;

   assign emit_go   = emit_full_ff && (!rsp_valid_ff || !rsp_stall);
   assign emit_done = emit_go && (corner_ff == LAST_CORNER);
   assign xfer      = work_full_ff && !arr_v_ff && (!emit_full_ff || emit_done);

   assign start    = !busy_ff && !q_empty && (!work_full_ff || xfer);
   assign issue_v  = start || busy_ff;
   assign issue_ph = busy_ff ? ph_ff : FETCH_LAT_U;
   assign q_pop    = issue_v && (issue_ph == FETCH_LON_B);

   always_comb begin
      case (issue_ph)
         FETCH_LAT_U: issue_phase = q_data.lat_u;
         FETCH_LAT_L: issue_phase = q_data.lat_l;
         FETCH_LON_A: issue_phase = q_data.lon_a;
         FETCH_LON_B: issue_phase = q_data.lon_b;
         default:     issue_phase = q_data.lat_u;
      endcase
      sin_ref = quarter_map(issue_phase);
      cos_ref = quarter_map(issue_phase + QUARTER_TURN);
   end

   uvs_sine_rom u_rom (
      .clock  (clock),
      .addr_a (sin_ref.addr),
      .addr_b (cos_ref.addr),
      .data_a (rom_sin),
      .data_b (rom_cos)
   );

   always_comb begin
      sval     = trig_value(arr_sin_ff.neg, arr_sin_ff.full, rom_sin);
      cval     = trig_value(arr_cos_ff.neg, arr_cos_ff.full, rom_cos);
      rad_s    = signed'({1'b0, radius});
      ring_rnd = round_q16(PROD_W'(rad_s) * PROD_W'(cval));
      vy_rnd   = round_q16(PROD_W'(rad_s) * PROD_W'(sval));
   end

   always_comb begin
      busy_in = busy_ff;
      ph_in   = ph_ff;
      if (issue_v) begin
         busy_in = (issue_ph != FETCH_LON_B);
         ph_in   = issue_ph + 1'b1;
      end
      work_full_in = work_full_ff;
      if (xfer) begin
         work_full_in = 1'b0;
      end
      if (q_pop) begin
         work_full_in = 1'b1;
      end
      emit_full_in = emit_full_ff;
      if (xfer) begin
         emit_full_in = 1'b1;
      end else if (emit_done) begin
         emit_full_in = 1'b0;
      end
      corner_in = corner_ff;
      if (emit_go) begin
         corner_in = emit_done ? '0 : corner_ff + 1'b1;
      end
   end

   always_comb begin
      lower    = LOWER_RING[corner_ff];
      nxt      = NEXT_LON[corner_ff];
      ring_sel = lower ? e_ring_l_ff : e_ring_u_ff;
      vy_sel   = lower ? e_vy_l_ff : e_vy_u_ff;
      sin_sel  = nxt ? e_sin_b_ff : e_sin_a_ff;
      cos_sel  = nxt ? e_cos_b_ff : e_cos_a_ff;
      vx_rnd   = round_q16(PROD_W'(ring_sel) * PROD_W'(sin_sel));
      vz_rnd   = round_q16(PROD_W'(ring_sel) * PROD_W'(cos_sel));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ph_ff        <= FETCH_LAT_U;
         arr_v_ff     <= 1'b0;
         work_full_ff <= 1'b0;
         emit_full_ff <= 1'b0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         ph_ff        <= ph_in;
         arr_v_ff     <= issue_v;
         work_full_ff <= work_full_in;
         emit_full_ff <= emit_full_in;
         corner_ff    <= corner_in;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      arr_ph_ff  <= issue_ph;
      arr_sin_ff <= sin_ref;
      arr_cos_ff <= cos_ref;
      if (q_pop) begin
         work_bad_ff <= q_data.bad;
      end
      if (arr_v_ff) begin
         case (arr_ph_ff)
            FETCH_LAT_U: begin
               w_ring_u_ff <= ring_rnd;
               w_vy_u_ff   <= vy_rnd;
            end
            FETCH_LAT_L: begin
               w_ring_l_ff <= ring_rnd;
               w_vy_l_ff   <= vy_rnd;
            end
            FETCH_LON_A: begin
               w_sin_a_ff <= sval;
               w_cos_a_ff <= cval;
            end
            FETCH_LON_B: begin
               w_sin_b_ff <= sval;
               w_cos_b_ff <= cval;
            end
            default: begin
               w_sin_b_ff <= sval;
               w_cos_b_ff <= cval;
            end
         endcase
      end
      if (xfer) begin
         e_bad_ff    <= work_bad_ff;
         e_ring_u_ff <= w_ring_u_ff;
         e_ring_l_ff <= w_ring_l_ff;
         e_vy_u_ff   <= w_vy_u_ff;
         e_vy_l_ff   <= w_vy_l_ff;
         e_sin_a_ff  <= w_sin_a_ff;
         e_cos_a_ff  <= w_cos_a_ff;
         e_sin_b_ff  <= w_sin_b_ff;
         e_cos_b_ff  <= w_cos_b_ff;
      end
      if (emit_go) begin
         rsp_vx_ff     <= e_bad_ff ? '0 : vx_rnd;
         rsp_vy_ff     <= e_bad_ff ? '0 : vy_sel;
         rsp_vz_ff     <= e_bad_ff ? '0 : vz_rnd;
         rsp_corner_ff <= corner_ff;
         rsp_last_ff   <= (corner_ff == LAST_CORNER);
         rsp_bad_ff    <= e_bad_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vx        = rsp_vx_ff;
   assign rsp_vy        = rsp_vy_ff;
   assign rsp_vz        = rsp_vz_ff;
   assign rsp_corner    = rsp_corner_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_index = rsp_bad_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_vx_ff == '0 && rsp_vy_ff == '0 && rsp_vz_ff == '0)
      else $error("bad quad with nonzero coordinates");

   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      emit_full_ff |-> corner_ff <= LAST_CORNER)
      else $error("corner counter out of range");

   a_no_fetch_over_work: assert property (@(posedge clock) disable iff (reset)
      work_full_ff |-> !busy_ff)
      else $error("lookups issued into an occupied work set");

endmodule
